### rtl/core/mda_pkg.sv
package mda_pkg;

   // Opcodes.
   localparam logic [5:0] OPC_RTYPE   = 6'h00;
   localparam logic [5:0] OPC_J       = 6'h02;
   localparam logic [5:0] OPC_JAL     = 6'h03;
   localparam logic [5:0] OPC_BEQ     = 6'h04;
   localparam logic [5:0] OPC_BNE     = 6'h05;
   localparam logic [5:0] OPC_ADDI    = 6'h08;
   localparam logic [5:0] OPC_ADDIU   = 6'h09;
   localparam logic [5:0] OPC_SLTI    = 6'h0a;
   localparam logic [5:0] OPC_SLTIU   = 6'h0b;
   localparam logic [5:0] OPC_ANDI    = 6'h0c;
   localparam logic [5:0] OPC_ORI     = 6'h0d;
   localparam logic [5:0] OPC_LUI     = 6'h0f;
   localparam logic [5:0] OPC_BEQ_ALT = 6'h20;
   localparam logic [5:0] OPC_LW      = 6'h23;
   localparam logic [5:0] OPC_LBU     = 6'h24;
   localparam logic [5:0] OPC_LHU     = 6'h25;
   localparam logic [5:0] OPC_SB      = 6'h28;
   localparam logic [5:0] OPC_SH      = 6'h29;
   localparam logic [5:0] OPC_SW      = 6'h2b;
   localparam logic [5:0] OPC_LL      = 6'h30;
   localparam logic [5:0] OPC_SC      = 6'h38;

   // Function codes of R-type instructions.
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_JALR = 6'h09;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2a;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   localparam logic [4:0] LINK_REG = 5'd31;

   localparam logic [1:0] SIZE_WORD = 2'd0;
   localparam logic [1:0] SIZE_BYTE = 2'd1;
   localparam logic [1:0] SIZE_HALF = 2'd2;

   localparam logic [1:0] CLASS_NOP   = 2'd0;
   localparam logic [1:0] CLASS_RTYPE = 2'd1;
   localparam logic [1:0] CLASS_ITYPE = 2'd2;
   localparam logic [1:0] CLASS_JTYPE = 2'd3;

   typedef enum logic [3:0] {
      ALU_ZERO, ALU_ADD, ALU_AND, ALU_OR, ALU_SLT, ALU_SLTU, ALU_SLL, ALU_SRL,
      ALU_SRA, ALU_SUB, ALU_EQ, ALU_NE, ALU_NOR, ALU_LUI, ALU_PASS
   } alu_op_type;

   typedef struct packed {
      logic [31:0]        instruction;
      logic [31:0]        inst_pc;
      logic signed [31:0] rs_value;
      logic signed [31:0] rt_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] alu_out;
      logic [31:0]        link_value;
      logic [4:0]         dest_register;
      logic               reg_write;
      logic               mem_read;
      logic               mem_write;
      logic               mem_to_reg;
      logic [1:0]         mem_size;
      logic               jump;
      logic               branch_taken;
      logic [31:0]        next_pc;
      logic [1:0]         instr_class;
   } rsp_type;

endpackage

### rtl/core/mda_exec.sv
module mda_exec (
   input  mda_pkg::req_type req,
   output mda_pkg::rsp_type rsp
);

   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sa;
   logic [15:0] raw;
   logic [31:0] simm;
   logic [31:0] imm;
   logic [31:0] pc4;
   logic        rtype;
   logic        jr_like;
   logic        is_load;
   logic        is_store;
   logic        is_branch;
   logic        is_jump;
   logic        alu_src;
   logic        shift_op;
   logic        taken;
   mda_pkg::alu_op_type sel;
   logic [31:0] a;
   logic [31:0] b;
   logic [4:0]  sh;
   logic [31:0] res;

   always_comb begin
      op       = req.instruction[31:26];
      rt       = req.instruction[20:16];
      rd       = req.instruction[15:11];
      sa       = req.instruction[10:6];
      fn       = req.instruction[5:0];
      raw      = req.instruction[15:0];
      simm     = {{16{raw[15]}}, raw};
      imm      = (op inside {mda_pkg::OPC_ANDI, mda_pkg::OPC_ORI, mda_pkg::OPC_LUI})
                 ? {16'h0000, raw} : simm;
      pc4      = req.inst_pc + 32'd4;
      rtype    = (op == mda_pkg::OPC_RTYPE);
      jr_like  = rtype && (fn inside {mda_pkg::FN_JR, mda_pkg::FN_JALR});
      is_load  = op inside {mda_pkg::OPC_LW, mda_pkg::OPC_LBU, mda_pkg::OPC_LHU,
                            mda_pkg::OPC_LL};
      is_store = op inside {mda_pkg::OPC_SW, mda_pkg::OPC_SB, mda_pkg::OPC_SH,
                            mda_pkg::OPC_SC};
      is_branch = op inside {mda_pkg::OPC_BEQ, mda_pkg::OPC_BNE, mda_pkg::OPC_BEQ_ALT};
      is_jump  = jr_like || (op inside {mda_pkg::OPC_J, mda_pkg::OPC_JAL});
      alu_src  = !(op inside {mda_pkg::OPC_RTYPE, mda_pkg::OPC_BEQ, mda_pkg::OPC_BNE});
      shift_op = rtype && (fn inside {mda_pkg::FN_SLL, mda_pkg::FN_SRL, mda_pkg::FN_SRA});

      if (rtype) begin
         case (fn)
            mda_pkg::FN_ADD, mda_pkg::FN_ADDU: sel = mda_pkg::ALU_ADD;
            mda_pkg::FN_AND:                   sel = mda_pkg::ALU_AND;
            mda_pkg::FN_OR:                    sel = mda_pkg::ALU_OR;
            mda_pkg::FN_NOR:                   sel = mda_pkg::ALU_NOR;
            mda_pkg::FN_SLT:                   sel = mda_pkg::ALU_SLT;
            mda_pkg::FN_SLTU:                  sel = mda_pkg::ALU_SLTU;
            mda_pkg::FN_SLL:                   sel = mda_pkg::ALU_SLL;
            mda_pkg::FN_SRL:                   sel = mda_pkg::ALU_SRL;
            mda_pkg::FN_SRA:                   sel = mda_pkg::ALU_SRA;
            mda_pkg::FN_SUB, mda_pkg::FN_SUBU: sel = mda_pkg::ALU_SUB;
            mda_pkg::FN_JR, mda_pkg::FN_JALR:  sel = mda_pkg::ALU_PASS;
            default:                           sel = mda_pkg::ALU_ZERO;
         endcase
      end else begin
         case (op)
            mda_pkg::OPC_ADDI, mda_pkg::OPC_ADDIU, mda_pkg::OPC_LW, mda_pkg::OPC_LBU,
            mda_pkg::OPC_LHU, mda_pkg::OPC_LL, mda_pkg::OPC_SB, mda_pkg::OPC_SH,
            mda_pkg::OPC_SW, mda_pkg::OPC_SC:       sel = mda_pkg::ALU_ADD;
            mda_pkg::OPC_ANDI:                      sel = mda_pkg::ALU_AND;
            mda_pkg::OPC_ORI:                       sel = mda_pkg::ALU_OR;
            mda_pkg::OPC_BEQ, mda_pkg::OPC_BEQ_ALT: sel = mda_pkg::ALU_EQ;
            mda_pkg::OPC_BNE:                       sel = mda_pkg::ALU_NE;
            mda_pkg::OPC_SLTI:                      sel = mda_pkg::ALU_SLT;
            mda_pkg::OPC_SLTIU:                     sel = mda_pkg::ALU_SLTU;
            mda_pkg::OPC_LUI:                       sel = mda_pkg::ALU_LUI;
            default:                                sel = mda_pkg::ALU_ZERO;
         endcase
      end

      if (shift_op) begin
         a = req.rt_value;
         b = {27'd0, sa};
      end else begin
         a = req.rs_value;
         b = alu_src ? imm : req.rt_value;
      end
      sh = b[4:0];

      case (sel)
         mda_pkg::ALU_ADD:  res = a + b;
         mda_pkg::ALU_AND:  res = a & b;
         mda_pkg::ALU_OR:   res = a | b;
         mda_pkg::ALU_NOR:  res = ~(a | b);
         mda_pkg::ALU_SLT:  res = {31'd0, ($signed(a) < $signed(b))};
         mda_pkg::ALU_SLTU: res = {31'd0, (a < b)};
         mda_pkg::ALU_SLL:  res = a << sh;
         mda_pkg::ALU_SRL:  res = a >> sh;
         mda_pkg::ALU_SRA:  res = $unsigned($signed(a) >>> sh);
         mda_pkg::ALU_SUB:  res = a - b;
         mda_pkg::ALU_EQ:   res = {31'd0, (a == b)};
         mda_pkg::ALU_NE:   res = {31'd0, (a != b)};
         mda_pkg::ALU_LUI:  res = {b[15:0], 16'h0000};
         mda_pkg::ALU_PASS: res = a;
         default:           res = 32'd0;
      endcase

      taken = is_branch && (res != 32'd0);

      rsp.alu_out    = $signed(res);
      rsp.reg_write  = !(is_store || (op inside {mda_pkg::OPC_BEQ, mda_pkg::OPC_BNE,
                                                 mda_pkg::OPC_J})
                         || (rtype && fn == mda_pkg::FN_JR));
      rsp.mem_read     = is_load;
      rsp.mem_write    = is_store;
      rsp.mem_to_reg   = is_load;
      rsp.jump         = is_jump;
      rsp.branch_taken = taken;

      if (jr_like) begin
         rsp.next_pc = req.rs_value;
      end else if (op inside {mda_pkg::OPC_J, mda_pkg::OPC_JAL}) begin
         rsp.next_pc = {pc4[31:28], req.instruction[25:0], 2'b00};
      end else if (taken) begin
         rsp.next_pc = pc4 + {simm[29:0], 2'b00};
      end else begin
         rsp.next_pc = pc4;
      end

      if (op == mda_pkg::OPC_JAL) begin
         rsp.link_value = req.inst_pc + 32'd8;
      end else if (rtype && fn == mda_pkg::FN_JALR) begin
         rsp.link_value = pc4;
      end else begin
         rsp.link_value = 32'd0;
      end

      if (op == mda_pkg::OPC_JAL) begin
         rsp.dest_register = mda_pkg::LINK_REG;
      end else begin
         rsp.dest_register = rtype ? rd : rt;
      end

      if (op inside {mda_pkg::OPC_LBU, mda_pkg::OPC_SB}) begin
         rsp.mem_size = mda_pkg::SIZE_BYTE;
      end else if (op inside {mda_pkg::OPC_LHU, mda_pkg::OPC_SH}) begin
         rsp.mem_size = mda_pkg::SIZE_HALF;
      end else begin
         rsp.mem_size = mda_pkg::SIZE_WORD;
      end

      if (req.instruction == 32'd0) begin
         rsp.instr_class = mda_pkg::CLASS_NOP;
      end else if (rtype) begin
         rsp.instr_class = mda_pkg::CLASS_RTYPE;
      end else if (op inside {mda_pkg::OPC_J, mda_pkg::OPC_JAL}) begin
         rsp.instr_class = mda_pkg::CLASS_JTYPE;
      end else begin
         rsp.instr_class = mda_pkg::CLASS_ITYPE;
      end
   end

endmodule

### rtl/core/mips_decode_and_alu.sv
// Channel    Direction  Handshake             Payload
// req_       in         req_valid/req_stall   instruction, pc, rs and rt values
// rsp_       out        rsp_valid/rsp_stall   ALU result, controls, next pc
//
// One word per cycle unless rsp_stall holds; a taken word goes to the input
// register, then the result register, which drives rsp_. Throughput is set by
// the single decode and ALU pass between them. Reset clears both valid flags.
// A stalled result holds the result register; the input register still takes
// a word while it is empty, or the result register is empty or being drained.
module mips_decode_and_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_instruction,
   input  logic [31:0]        req_inst_pc,
   input  logic signed [31:0] req_rs_value,
   input  logic signed [31:0] req_rt_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_alu_out,
   output logic [31:0]        rsp_link_value,
   output logic [4:0]         rsp_dest_register,
   output logic               rsp_reg_write,
   output logic               rsp_mem_read,
   output logic               rsp_mem_write,
   output logic               rsp_mem_to_reg,
   output logic [1:0]         rsp_mem_size,
   output logic               rsp_jump,
   output logic               rsp_branch_taken,
   output logic [31:0]        rsp_next_pc,
   output logic [1:0]         rsp_instr_class
);

   logic             in_valid_ff;
   mda_pkg::req_type in_word_ff;
   logic             out_valid_ff;
   mda_pkg::rsp_type out_word_ff;
   mda_pkg::rsp_type out_word_in;
   logic             out_open;
   logic             in_open;

   assign out_open  = !out_valid_ff || !rsp_stall;
   assign in_open   = !in_valid_ff || out_open;
   assign req_stall = !in_open;

   mda_exec u_exec (
      .req (in_word_ff),
      .rsp (out_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_open) begin
            in_valid_ff <= req_valid;
         end
         if (out_open) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (in_open && req_valid) begin
         in_word_ff.instruction <= req_instruction;
         in_word_ff.inst_pc     <= req_inst_pc;
         in_word_ff.rs_value    <= req_rs_value;
         in_word_ff.rt_value    <= req_rt_value;
      end
      if (out_open && in_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_alu_out       = out_word_ff.alu_out;
   assign rsp_link_value    = out_word_ff.link_value;
   assign rsp_dest_register = out_word_ff.dest_register;
   assign rsp_reg_write     = out_word_ff.reg_write;
   assign rsp_mem_read      = out_word_ff.mem_read;
   assign rsp_mem_write     = out_word_ff.mem_write;
   assign rsp_mem_to_reg    = out_word_ff.mem_to_reg;
   assign rsp_mem_size      = out_word_ff.mem_size;
   assign rsp_jump          = out_word_ff.jump;
   assign rsp_branch_taken  = out_word_ff.branch_taken;
   assign rsp_next_pc       = out_word_ff.next_pc;
   assign rsp_instr_class   = out_word_ff.instr_class;

endmodule
